// ===== src/gppf_pkg.sv =====
// shared types and constants for the grid point proximity filter
`default_nettype none
package gppf_pkg;

    localparam int COORD_IN_W  = 20;
    localparam int STEP_W      = 17;
    localparam int TOL_W       = 40;
    localparam int ID_W        = 16;
    localparam int ROW_W       = 8;
    localparam int OUT_W       = 21;
    localparam int CFG_IDX_W   = 2;
    localparam int BASE_OFF_X  = 368;
    localparam int BASE_OFF_Y  = 688;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [1:0] {
        CMD_POINT,
        CMD_ANCHOR,
        CMD_SKIP
    } t_cmd_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_X = 2'd0,
        CFG_STEP_Y = 2'd1,
        CFG_TOL    = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        t_cmd_kind                    kind;
        logic signed [COORD_IN_W-1:0] x;
        logic signed [COORD_IN_W-1:0] y;
        logic [ID_W-1:0]              id;
        logic [ROW_W-1:0]             row;
    } t_cmd;

    typedef struct packed {
        logic signed [STEP_W-1:0] step_x;
        logic signed [STEP_W-1:0] step_y;
        logic [TOL_W-1:0]         tol;
    } t_cfg;

    typedef struct packed {
        logic [QPTR_W:0] level;
    } t_front_status;

    typedef struct packed {
        logic idle;
    } t_back_status;

endpackage
`default_nettype wire

// ===== src/gppf_if.sv =====
// channel interfaces: input items, result items and configuration writes
`default_nettype none
interface gppf_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   operation;
    logic signed [gppf_pkg::COORD_IN_W-1:0] coord_x;
    logic signed [gppf_pkg::COORD_IN_W-1:0] coord_y;
    logic                                   anchor_valid;
    logic [gppf_pkg::ID_W-1:0]              cluster_id;
    logic [gppf_pkg::ROW_W-1:0]             cluster_row;

    modport source (output valid, operation, coord_x, coord_y, anchor_valid,
                    cluster_id, cluster_row, input ready);
    modport sink (input valid, operation, coord_x, coord_y, anchor_valid,
                  cluster_id, cluster_row, output ready);
endinterface

interface gppf_out_if;
    logic                              valid;
    logic                              ready;
    logic [gppf_pkg::ID_W-1:0]         kept_cluster_id;
    logic [gppf_pkg::ROW_W-1:0]        kept_cluster_row;
    logic signed [gppf_pkg::OUT_W-1:0] grid_x;
    logic signed [gppf_pkg::OUT_W-1:0] grid_y;
    logic                              last;
    logic                              store_overflowed;

    modport source (output valid, kept_cluster_id, kept_cluster_row, grid_x, grid_y,
                    last, store_overflowed, input ready);
    modport sink (input valid, kept_cluster_id, kept_cluster_row, grid_x, grid_y,
                  last, store_overflowed, output ready);
endinterface

interface gppf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gppf_pkg::CFG_IDX_W-1:0]     index;
    logic [gppf_pkg::TOL_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/gppf_front.sv =====
// front end: accepts input items, classifies them and queues commands
`default_nettype none
module gppf_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    gppf_in_if.sink                       i_item,
    output gppf_pkg::t_cmd                o_cmd,
    output logic                          o_cmd_valid,
    input  wire logic                     i_cmd_ready,
    output gppf_pkg::t_front_status       o_status
);

    gppf_pkg::t_cmd                   r_q [gppf_pkg::QUEUE_DEPTH];
    logic [gppf_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [gppf_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [gppf_pkg::QPTR_W:0]        r_level;
    gppf_pkg::t_cmd                   n_cmd;
    logic                             push;
    logic                             pop;

    always_comb begin
        n_cmd.x   = i_item.coord_x;
        n_cmd.y   = i_item.coord_y;
        n_cmd.id  = i_item.cluster_id;
        n_cmd.row = i_item.cluster_row;
        if (!i_item.operation) begin
            n_cmd.kind = gppf_pkg::CMD_POINT;
        end else if (i_item.anchor_valid) begin
            n_cmd.kind = gppf_pkg::CMD_ANCHOR;
        end else begin
            n_cmd.kind = gppf_pkg::CMD_SKIP;
        end
    end

    assign i_item.ready = (r_level != (gppf_pkg::QPTR_W+1)'(gppf_pkg::QUEUE_DEPTH));
    assign o_cmd_valid  = (r_level != '0);
    assign o_cmd        = r_q[r_rd_ptr];
    assign o_status.level = r_level;
    assign push = i_item.valid && i_item.ready;
    assign pop  = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/gppf_back.sv =====
// back end: point store, grid walk, distance pipeline and result register
`default_nettype none
module gppf_back #(
    parameter int MAX_POINTS = 256,
    parameter int GRID_SIDE  = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  gppf_pkg::t_cfg             i_cfg,
    input  wire logic                  i_cmd_valid,
    input  gppf_pkg::t_cmd             i_cmd,
    output logic                       o_cmd_ready,
    output gppf_pkg::t_back_status     o_status,
    gppf_out_if.source                 o_result
);

    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int GIDX_W  = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int SPAN_W  = $clog2(GRID_SIDE) + gppf_pkg::STEP_W;
    localparam int BASE_W  = gppf_pkg::COORD_IN_W + 1;
    localparam int COORD_W = ((SPAN_W > BASE_W) ? SPAN_W : BASE_W) + 1;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int IN_W    = gppf_pkg::COORD_IN_W;
    localparam int ENT_W   = 2 * IN_W;

    // point store, x in the upper half
    logic [ENT_W-1:0]           r_mem [MAX_POINTS];

    gppf_pkg::t_state           r_state, n_state;
    logic [CNT_W-1:0]           r_count, n_count;
    logic                       r_ovf, n_ovf;
    logic [CNT_W-1:0]           r_k, n_k;
    logic [CNT_W-1:0]           r_scan_n, n_scan_n;
    logic                       r_near, n_near;
    logic signed [COORD_W-1:0]  r_gx, n_gx;
    logic signed [COORD_W-1:0]  r_gx0, n_gx0;
    logic signed [COORD_W-1:0]  r_gy, n_gy;
    logic [GIDX_W-1:0]          r_col, n_col;
    logic [GIDX_W-1:0]          r_grow, n_grow;
    logic                       r_have_pend, n_have_pend;
    logic signed [COORD_W-1:0]  r_pend_x, n_pend_x;
    logic signed [COORD_W-1:0]  r_pend_y, n_pend_y;
    logic [gppf_pkg::ID_W-1:0]  r_id, n_id;
    logic [gppf_pkg::ROW_W-1:0] r_row_id, n_row_id;
    logic                       r_ovf_lat, n_ovf_lat;

    logic                       r_out_valid, n_out_valid;
    logic [gppf_pkg::ID_W-1:0]  r_out_id, n_out_id;
    logic [gppf_pkg::ROW_W-1:0] r_out_row, n_out_row;
    logic [gppf_pkg::OUT_W-1:0] r_out_x, n_out_x;
    logic [gppf_pkg::OUT_W-1:0] r_out_y, n_out_y;
    logic                       r_out_last, n_out_last;
    logic                       r_out_ovf, n_out_ovf;

    logic [ENT_W-1:0]           r_rd_data;
    logic                       r_v0, r_v1, r_v2;
    logic signed [DIFF_W-1:0]   r_dx, r_dy;
    logic signed [SQ_W-1:0]     r_sqx, r_sqy;
    logic [SUM_W-1:0]           sq_dist;
    logic                       hit;

    logic                       issue;
    logic                       wr_en;
    logic                       out_free;
    logic                       grid_end;
    logic signed [COORD_W-1:0]  step_x_ext;
    logic signed [COORD_W-1:0]  step_y_ext;
    logic signed [COORD_W-1:0]  cmd_x_ext;
    logic signed [COORD_W-1:0]  cmd_y_ext;

    assign step_x_ext = {{(COORD_W-gppf_pkg::STEP_W){i_cfg.step_x[gppf_pkg::STEP_W-1]}},
                         i_cfg.step_x};
    assign step_y_ext = {{(COORD_W-gppf_pkg::STEP_W){i_cfg.step_y[gppf_pkg::STEP_W-1]}},
                         i_cfg.step_y};
    assign cmd_x_ext  = {{(COORD_W-IN_W){i_cmd.x[IN_W-1]}}, i_cmd.x};
    assign cmd_y_ext  = {{(COORD_W-IN_W){i_cmd.y[IN_W-1]}}, i_cmd.y};

    assign sq_dist  = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign hit      = r_v2 && (sq_dist <= SUM_W'(i_cfg.tol));
    assign out_free = !r_out_valid || o_result.ready;
    assign grid_end = (r_col == GIDX_W'(GRID_SIDE - 1)) && (r_grow == GIDX_W'(GRID_SIDE - 1));

    assign o_cmd_ready   = (r_state == gppf_pkg::ST_IDLE);
    assign o_status.idle = (r_state == gppf_pkg::ST_IDLE);

    assign o_result.valid            = r_out_valid;
    assign o_result.kept_cluster_id  = r_out_id;
    assign o_result.kept_cluster_row = r_out_row;
    assign o_result.grid_x           = r_out_x;
    assign o_result.grid_y           = r_out_y;
    assign o_result.last             = r_out_last;
    assign o_result.store_overflowed = r_out_ovf;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_k         = r_k;
        n_scan_n    = r_scan_n;
        n_near      = r_near | hit;
        n_gx        = r_gx;
        n_gx0       = r_gx0;
        n_gy        = r_gy;
        n_col       = r_col;
        n_grow      = r_grow;
        n_have_pend = r_have_pend;
        n_pend_x    = r_pend_x;
        n_pend_y    = r_pend_y;
        n_id        = r_id;
        n_row_id    = r_row_id;
        n_ovf_lat   = r_ovf_lat;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_id    = r_out_id;
        n_out_row   = r_out_row;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        issue       = 1'b0;
        wr_en       = 1'b0;

        unique case (r_state)
            gppf_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        gppf_pkg::CMD_POINT: begin
                            if (r_count != CNT_W'(MAX_POINTS)) begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        gppf_pkg::CMD_SKIP: begin
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                        gppf_pkg::CMD_ANCHOR: begin
                            n_scan_n    = r_count;
                            n_count     = '0;
                            n_ovf       = 1'b0;
                            n_ovf_lat   = r_ovf;
                            n_id        = i_cmd.id;
                            n_row_id    = i_cmd.row;
                            n_gx0       = cmd_x_ext - COORD_W'(gppf_pkg::BASE_OFF_X);
                            n_gx        = cmd_x_ext - COORD_W'(gppf_pkg::BASE_OFF_X);
                            n_gy        = cmd_y_ext - COORD_W'(gppf_pkg::BASE_OFF_Y);
                            n_col       = '0;
                            n_grow      = '0;
                            n_have_pend = 1'b0;
                            n_k         = '0;
                            n_near      = 1'b0;
                            n_state     = gppf_pkg::ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            gppf_pkg::ST_SCAN: begin
                if (r_k != r_scan_n) begin
                    issue = 1'b1;
                    n_k   = r_k + 1'b1;
                end else begin
                    n_state = gppf_pkg::ST_DRAIN;
                end
            end
            gppf_pkg::ST_DRAIN: begin
                if (!(r_v0 || r_v1 || r_v2)) begin
                    n_state = gppf_pkg::ST_DECIDE;
                end
            end
            gppf_pkg::ST_DECIDE: begin
                // a kept point releases the one held before it, so last can be marked
                if (r_near || !r_have_pend || out_free) begin
                    if (!r_near) begin
                        if (r_have_pend) begin
                            n_out_valid = 1'b1;
                            n_out_id    = r_id;
                            n_out_row   = r_row_id;
                            n_out_x     = r_pend_x[gppf_pkg::OUT_W-1:0];
                            n_out_y     = r_pend_y[gppf_pkg::OUT_W-1:0];
                            n_out_last  = 1'b0;
                            n_out_ovf   = r_ovf_lat;
                        end
                        n_pend_x    = r_gx;
                        n_pend_y    = r_gy;
                        n_have_pend = 1'b1;
                    end
                    if (grid_end) begin
                        n_state = gppf_pkg::ST_FLUSH;
                    end else begin
                        if (r_col == GIDX_W'(GRID_SIDE - 1)) begin
                            n_col  = '0;
                            n_grow = r_grow + 1'b1;
                            n_gx   = r_gx0;
                            n_gy   = r_gy + step_y_ext;
                        end else begin
                            n_col = r_col + 1'b1;
                            n_gx  = r_gx + step_x_ext;
                        end
                        n_k     = '0;
                        n_near  = 1'b0;
                        n_state = gppf_pkg::ST_SCAN;
                    end
                end
            end
            gppf_pkg::ST_FLUSH: begin
                if (!r_have_pend) begin
                    n_state = gppf_pkg::ST_IDLE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = r_id;
                    n_out_row   = r_row_id;
                    n_out_x     = r_pend_x[gppf_pkg::OUT_W-1:0];
                    n_out_y     = r_pend_y[gppf_pkg::OUT_W-1:0];
                    n_out_last  = 1'b1;
                    n_out_ovf   = r_ovf_lat;
                    n_have_pend = 1'b0;
                    n_state     = gppf_pkg::ST_IDLE;
                end
            end
            default: n_state = gppf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gppf_pkg::ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_have_pend <= n_have_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_scan_n   <= n_scan_n;
        r_near     <= n_near;
        r_gx       <= n_gx;
        r_gx0      <= n_gx0;
        r_gy       <= n_gy;
        r_col      <= n_col;
        r_grow     <= n_grow;
        r_pend_x   <= n_pend_x;
        r_pend_y   <= n_pend_y;
        r_id       <= n_id;
        r_row_id   <= n_row_id;
        r_ovf_lat  <= n_ovf_lat;
        r_out_id   <= n_out_id;
        r_out_row  <= n_out_row;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[ADDR_W-1:0]] <= {i_cmd.x, i_cmd.y};
        end
        r_rd_data <= r_mem[r_k[ADDR_W-1:0]];
    end

    // distance pipeline: read, difference, square, then add and compare into r_near
    always_ff @(posedge i_clk) begin
        r_dx  <= {{(DIFF_W-COORD_W){r_gx[COORD_W-1]}}, r_gx}
               - {{(DIFF_W-IN_W){r_rd_data[ENT_W-1]}}, r_rd_data[ENT_W-1:IN_W]};
        r_dy  <= {{(DIFF_W-COORD_W){r_gy[COORD_W-1]}}, r_gy}
               - {{(DIFF_W-IN_W){r_rd_data[IN_W-1]}}, r_rd_data[IN_W-1:0]};
        r_sqx <= r_dx * r_dx;
        r_sqy <= r_dy * r_dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

endmodule
`default_nettype wire

// ===== src/grid_point_proximity_filter.sv =====
// top level: a point item passes through the command queue and is written into the point store
// once the back end is idle; point items flow one per cycle while the queue has room and the
//   back end is idle; each anchor grid point reads all stored points via the single read port
// results leave through a one-entry output register; a stalled output holds the grid walk
// reset: synchronous active low, zeroes queue pointers, state, counters, flags and config;
//   datapath registers and point store contents stay undefined and need no clearing pass
`default_nettype none
module grid_point_proximity_filter #(
    parameter int MAX_POINTS = 256,
    parameter int GRID_SIDE  = 6
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gppf_in_if.sink    i_item,
    gppf_out_if.source o_result,
    gppf_cfg_if.sink   i_cfg
);

    gppf_pkg::t_cfg            r_cfg;
    gppf_pkg::t_cmd            cmd;
    logic                      cmd_valid;
    logic                      cmd_ready;
    gppf_pkg::t_front_status   front_status;
    gppf_pkg::t_back_status    back_status;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (gppf_pkg::t_cfg_idx'(i_cfg.index))
                gppf_pkg::CFG_STEP_X: r_cfg.step_x <= i_cfg.data[gppf_pkg::STEP_W-1:0];
                gppf_pkg::CFG_STEP_Y: r_cfg.step_y <= i_cfg.data[gppf_pkg::STEP_W-1:0];
                gppf_pkg::CFG_TOL:    r_cfg.tol    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    gppf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_status    (front_status)
    );

    gppf_back #(
        .MAX_POINTS (MAX_POINTS),
        .GRID_SIDE  (GRID_SIDE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_status    (back_status),
        .o_result    (o_result)
    );

`ifndef SYNTHESIS
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");

    a_full_queue_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_status.level == (gppf_pkg::QPTR_W+1)'(gppf_pkg::QUEUE_DEPTH))
        |-> !i_item.ready)
        else $error("input taken while command queue full");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_status.idle && (front_status.level == '0) && !o_result.valid)
        |=> !o_result.valid)
        else $error("result appeared with no command in flight");
`endif

endmodule
`default_nettype wire
